>>> rtl/ps2mt_pkg.sv
package ps2mt_pkg;

  localparam int POS_BITS = 12;
  localparam int CFG_BITS = 13;
  localparam int LIM_W = (POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS;
  localparam int SUM_W = POS_BITS + 2;

  localparam logic [7:0] HOT_PLUG_BYTE = 8'hAA;
  localparam int HDR_ONE_BIT = 3;
  localparam int SIGN_X_BIT  = 4;
  localparam int SIGN_Y_BIT  = 5;
  localparam int OVF_X_BIT   = 6;
  localparam int OVF_Y_BIT   = 7;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DX     = 3'b010,
    PH_DY     = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] header;
    logic [7:0] dx;
    pos_t       cur_x;
    pos_t       cur_y;
  } track_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] header_bits;
    pos_t       pos_x;
    pos_t       pos_y;
    logic       status;
  } result_t;

  // highest legal coordinate for a screen size; zero acts as one, saturates at the top
  function automatic pos_t limit_of(input logic [CFG_BITS-1:0] size);
    logic [LIM_W-1:0] m;
    m = (size == '0) ? '0 : (LIM_W'(size) - LIM_W'(1));
    if ((m >> POS_BITS) != '0) begin
      return '1;
    end
    return pos_t'(m);
  endfunction

endpackage

>>> rtl/ps2mt_update.sv
module ps2mt_update (
  input  ps2mt_pkg::track_t cur,
  input  logic [7:0]        rx_byte,
  input  ps2mt_pkg::pos_t   lim_x,
  input  ps2mt_pkg::pos_t   lim_y,
  output ps2mt_pkg::track_t nxt,
  output ps2mt_pkg::result_t res
);
  import ps2mt_pkg::*;

  logic signed [SUM_W-1:0] dx_s;
  logic signed [SUM_W-1:0] dy_s;
  logic signed [SUM_W-1:0] nx;
  logic signed [SUM_W-1:0] ny;
  logic signed [SUM_W-1:0] lx_s;
  logic signed [SUM_W-1:0] ly_s;
  pos_t                    clamp_x;
  pos_t                    clamp_y;

  // nine-bit deltas with the sign taken from the header
  assign dx_s = {{(SUM_W-8){cur.header[SIGN_X_BIT]}}, cur.dx};
  assign dy_s = {{(SUM_W-8){cur.header[SIGN_Y_BIT]}}, rx_byte};
  assign nx   = $signed({2'b00, cur.cur_x}) + dx_s;
  assign ny   = $signed({2'b00, cur.cur_y}) - dy_s;
  assign lx_s = $signed({2'b00, lim_x});
  assign ly_s = $signed({2'b00, lim_y});

  always_comb begin
    if (nx[SUM_W-1]) begin
      clamp_x = '0;
    end else if (nx > lx_s) begin
      clamp_x = lim_x;
    end else begin
      clamp_x = nx[POS_BITS-1:0];
    end
    if (ny[SUM_W-1]) begin
      clamp_y = '0;
    end else if (ny > ly_s) begin
      clamp_y = lim_y;
    end else begin
      clamp_y = ny[POS_BITS-1:0];
    end
  end

  always_comb begin
    nxt             = cur;
    res.valid       = 1'b0;
    res.header_bits = cur.header;
    res.pos_x       = cur.cur_x;
    res.pos_y       = cur.cur_y;
    res.status      = 1'b0;
    case (cur.phase)
      PH_DX: begin
        nxt.dx    = rx_byte;
        nxt.phase = PH_DY;
      end
      PH_DY: begin
        nxt.phase = PH_HEADER;
        res.valid = 1'b1;
        if (cur.header[OVF_X_BIT] || cur.header[OVF_Y_BIT]) begin
          res.status = 1'b1;
        end else begin
          nxt.cur_x = clamp_x;
          nxt.cur_y = clamp_y;
          res.pos_x = clamp_x;
          res.pos_y = clamp_y;
        end
      end
      default: begin
        nxt.phase = PH_HEADER;
        // skip hot-plug marker and bytes that cannot be a header
        if (rx_byte != HOT_PLUG_BYTE && rx_byte[HDR_ONE_BIT]) begin
          nxt.header = rx_byte;
          nxt.phase  = PH_DX;
        end
      end
    endcase
  end

endmodule

>>> rtl/ps2_mouse_packet_tracker_top.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    rx_byte
// result    out        out_valid / out_ready  header_bits, pos_x, pos_y, status
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte is taken every cycle while in_ready is high; a packet's result is registered and shows
// the cycle after its third byte is taken.
// in_ready drops only while a result waits and out_ready is low.
// reset clears the packet phase and the cursor and loads a 640 x 480 screen.
// the config port is always ready; the clamp limit is worked out at the write.
module ps2_mouse_packet_tracker_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 header_bits,
  output ps2mt_pkg::pos_t            pos_x,
  output ps2mt_pkg::pos_t            pos_y,
  output logic                       status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [ps2mt_pkg::CFG_BITS-1:0] cfg_data
);
  import ps2mt_pkg::*;

  track_t  track;
  track_t  track_next;
  result_t res_next;
  pos_t    lim_x;
  pos_t    lim_y;
  logic    in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  ps2mt_update u_update (
    .cur     (track),
    .rx_byte (rx_byte),
    .lim_x   (lim_x),
    .lim_y   (lim_y),
    .nxt     (track_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_x <= limit_of(WIDTH_RESET);
      lim_y <= limit_of(HEIGHT_RESET);
    end else if (cfg_valid) begin
      if (cfg_reg_t'(cfg_index) == REG_SCREEN_WIDTH) begin
        lim_x <= limit_of(cfg_data);
      end else begin
        lim_y <= limit_of(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track.phase  <= PH_HEADER;
      track.header <= '0;
      track.dx     <= '0;
      track.cur_x  <= '0;
      track.cur_y  <= '0;
    end else if (in_xfer) begin
      track <= track_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= res_next.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload loads only for a completed packet
  always_ff @(posedge clk) begin
    if (in_xfer && res_next.valid) begin
      header_bits <= res_next.header_bits;
      pos_x       <= res_next.pos_x;
      pos_y       <= res_next.pos_y;
      status      <= res_next.status;
    end
  end

endmodule

>>> sim/testbench.sv
module testbench;
  import ps2mt_pkg::*;

  localparam int SIGN_SPAN = 256;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_CYCLES = 400;
  localparam int PHASE_COUNT = 9;
  localparam int BYTES_PER_PHASE = 215;
  localparam int RANDOM_SIZE = -1;

  localparam logic [7:0] OPENING_BYTES [29] = '{
    8'hAA, 8'h00,
    8'h08, 8'hFF, 8'h00,  8'h08, 8'hFF, 8'h00,  8'h08, 8'hFF, 8'h00,
    8'h38, 8'h00, 8'h00,  8'h38, 8'h00, 8'h00,
    8'h18, 8'h80, 8'h00,
    8'hCF, 8'hAA, 8'h55,
    8'h4F, 8'h01, 8'h02,
    8'h28, 8'h00, 8'h7F
  };

  localparam int SCREEN_W [PHASE_COUNT] = '{1, 0, 4096, 8191, 640, 5, RANDOM_SIZE,
                                             RANDOM_SIZE, 2};
  localparam int SCREEN_H [PHASE_COUNT] = '{1, 0, 4096, 8191, 480, 3000, RANDOM_SIZE,
                                             RANDOM_SIZE, 8191};

  typedef struct {
    logic [7:0] hdr;
    pos_t       x;
    pos_t       y;
    logic       dropped;
  } mouse_report_t;

  class packet_scoreboard;
    phase_t              phase;
    logic [7:0]          hdr_q;
    logic [7:0]          dx_q;
    pos_t                cur_x;
    pos_t                cur_y;
    logic [CFG_BITS-1:0] width_q;
    logic [CFG_BITS-1:0] height_q;
    mouse_report_t       reports[$];
    int                  mismatches;
    int                  checked;
    int                  dropped_seen;
    int                  skipped;
    int                  consumed;

    function new();
      phase = PH_HEADER;
      hdr_q = '0;
      dx_q = '0;
      cur_x = '0;
      cur_y = '0;
      width_q = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      mismatches = 0;
      checked = 0;
      dropped_seen = 0;
      skipped = 0;
      consumed = 0;
    endfunction

    function void set_screen(cfg_reg_t idx, logic [CFG_BITS-1:0] v);
      if (idx == REG_SCREEN_WIDTH) width_q = v;
      else height_q = v;
    endfunction

    // zero size behaves as one, anything past the coordinate range saturates
    function int screen_limit(logic [CFG_BITS-1:0] size);
      int m;
      m = (size == '0) ? 0 : int'(size) - 1;
      if (m > (1 << POS_BITS) - 1) m = (1 << POS_BITS) - 1;
      return m;
    endfunction

    function pos_t clamp_pos(int v, int hi);
      if (v < 0) return '0;
      if (v > hi) return pos_t'(hi);
      return pos_t'(v);
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
    endfunction

    function void note_byte(logic [7:0] b);
      mouse_report_t r;
      int dx;
      int dy;
      case (phase)
        PH_DX: begin
          dx_q = b;
          phase = PH_DY;
          consumed++;
        end
        PH_DY: begin
          phase = PH_HEADER;
          consumed++;
          r.hdr = hdr_q;
          r.dropped = hdr_q[OVF_X_BIT] | hdr_q[OVF_Y_BIT];
          if (!r.dropped) begin
            dx = int'(dx_q) - (hdr_q[SIGN_X_BIT] ? SIGN_SPAN : 0);
            dy = int'(b) - (hdr_q[SIGN_Y_BIT] ? SIGN_SPAN : 0);
            // rows grow downward, so dy is taken away
            cur_x = clamp_pos(int'(cur_x) + dx, screen_limit(width_q));
            cur_y = clamp_pos(int'(cur_y) - dy, screen_limit(height_q));
          end
          r.x = cur_x;
          r.y = cur_y;
          reports.push_back(r);
        end
        default: begin
          phase = PH_HEADER;
          if (b == HOT_PLUG_BYTE || !b[HDR_ONE_BIT]) begin
            skipped++;
          end else begin
            hdr_q = b;
            phase = PH_DX;
            consumed++;
          end
        end
      endcase
    endfunction

    function void check_report(logic [7:0] h, pos_t x, pos_t y, logic st);
      mouse_report_t e;
      if (reports.size() == 0) begin
        note_mismatch($sformatf("unexpected report hdr %02h x %0d y %0d status %0b",
                                h, x, y, st));
        return;
      end
      e = reports.pop_front();
      checked++;
      if (e.dropped) dropped_seen++;
      if (h !== e.hdr || x !== e.x || y !== e.y || st !== e.dropped)
        note_mismatch($sformatf({"report %0d: expected hdr %02h x %0d y %0d status %0b,",
                                 " got hdr %02h x %0d y %0d status %0b"},
                                checked, e.hdr, e.x, e.y, e.dropped, h, x, y, st));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          header_bits;
  pos_t                pos_x;
  pos_t                pos_y;
  logic                status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [0:0]          cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  packet_scoreboard sb;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit drift_right = 1'b1;
  bit drift_down = 1'b1;
  int hold_cycles = 0;

  ps2_mouse_packet_tracker_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .header_bits(header_bits),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_screen(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note_byte(rx_byte);
      if (out_valid && out_ready) sb.check_report(header_bits, pos_x, pos_y, status);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_calm = ~tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_packet(input bit force_drop);
    logic [7:0] h;
    logic [7:0] dxb;
    logic [7:0] dyb;
    h = 8'($urandom);
    h[HDR_ONE_BIT] = 1'b1;
    if (h == HOT_PLUG_BYTE) h[0] = 1'b1;
    if ($urandom_range(0, 9) != 0) begin
      h[OVF_X_BIT] = 1'b0;
      h[OVF_Y_BIT] = 1'b0;
    end
    if (force_drop) h[OVF_Y_BIT] = 1'b1;
    dxb = 8'($urandom);
    dyb = 8'($urandom);
    // full-scale pushes so the cursor reaches the screen edges
    if ($urandom_range(0, 2) == 0) begin
      h[SIGN_X_BIT] = ~drift_right;
      dxb = drift_right ? 8'hFF : 8'h00;
      h[SIGN_Y_BIT] = drift_down;
      dyb = drift_down ? 8'h00 : 8'hFF;
    end
    send_byte(h);
    send_byte(dxb);
    send_byte(dyb);
  endtask

  task automatic run_random(input int goal);
    int start;
    logic [7:0] noise;
    start = sb.consumed;
    send_packet(1'b1);
    while (sb.consumed - start < goal) begin
      if ($urandom_range(0, 39) == 0) drift_right = ~drift_right;
      if ($urandom_range(0, 39) == 0) drift_down = ~drift_down;
      if ($urandom_range(0, 6) == 0) begin
        noise = 8'($urandom);
        case ($urandom_range(0, 2))
          0: noise = HOT_PLUG_BYTE;
          1: noise[HDR_ONE_BIT] = 1'b0;
          default: ;
        endcase
        send_byte(noise);
      end else begin
        send_packet(1'b0);
      end
    end
  endtask

  // stop offering, let every report come back, then let the block settle
  task automatic finish_phase();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) sb.note_mismatch("reports stopped arriving");
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        repeat (hold_cycles) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
        hold_cycles = 0;
      end
      if ($urandom_range(0, 31) == 0) rx_calm = ~rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int w;
    int h;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    finish_phase();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      w = (SCREEN_W[p] == RANDOM_SIZE) ? $urandom_range(1, 4096) : SCREEN_W[p];
      h = (SCREEN_H[p] == RANDOM_SIZE) ? $urandom_range(1, 4096) : SCREEN_H[p];
      write_reg(REG_SCREEN_WIDTH, CFG_BITS'(w));
      write_reg(REG_SCREEN_HEIGHT, CFG_BITS'(h));
      if (p == 2) hold_cycles = STALL_CYCLES;
      run_random(BYTES_PER_PHASE);
      finish_phase();
    end

    $display("%0d byte transfers used, %0d skipped while hunting for a header",
             sb.consumed, sb.skipped);
    $display("%0d packets checked (%0d dropped for overflow) over %0d screen sizes",
             sb.checked, sb.dropped_seen, PHASE_COUNT + 1);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
